// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the flattener core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCF_ASSERT_IMPLY(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BCF_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/bcf_pkg.sv =====
package bcf_pkg;

	localparam int SEGMENTS_DEFAULT  = 24;
	localparam int FRAC_BITS_DEFAULT = 16;
	localparam int COORD_W           = 32;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [1:0] ACT_BEGIN = 2'd0;
	localparam logic [1:0] ACT_POINT = 2'd1;
	localparam logic [1:0] ACT_QUAD  = 2'd2;
	localparam logic [1:0] ACT_CUBIC = 2'd3;

	// One classified command waiting for the back end.
	typedef struct packed {
		logic [1:0]                 kind;
		logic                       lead;
		logic signed [COORD_W-1:0]  p0_x;
		logic signed [COORD_W-1:0]  p0_y;
		logic signed [COORD_W-1:0]  c1_x;
		logic signed [COORD_W-1:0]  c1_y;
		logic signed [COORD_W-1:0]  c2_x;
		logic signed [COORD_W-1:0]  c2_y;
		logic signed [COORD_W-1:0]  e_x;
		logic signed [COORD_W-1:0]  e_y;
	} cmd_t;

endpackage

// ===== rtl/bcf_ifs.sv =====
interface bcf_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          action;
	logic signed [bcf_pkg::COORD_W-1:0]  ctrl1_x;
	logic signed [bcf_pkg::COORD_W-1:0]  ctrl1_y;
	logic signed [bcf_pkg::COORD_W-1:0]  ctrl2_x;
	logic signed [bcf_pkg::COORD_W-1:0]  ctrl2_y;
	logic signed [bcf_pkg::COORD_W-1:0]  end_x;
	logic signed [bcf_pkg::COORD_W-1:0]  end_y;

	modport source (output valid, action, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
		input ready);
	modport sink (input valid, action, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
		output ready);
endinterface

interface bcf_pt_if;
	logic                                valid;
	logic                                ready;
	logic signed [bcf_pkg::COORD_W-1:0]  point_x;
	logic signed [bcf_pkg::COORD_W-1:0]  point_y;
	logic                                last_point;

	modport source (output valid, point_x, point_y, last_point, input ready);
	modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

// ===== rtl/bcf_front.sv =====
module bcf_front (
	input  logic           clk,
	input  logic           arst_n,
	bcf_cmd_if.sink        cmd,
	input  logic           q_full,
	output logic           push,
	output bcf_pkg::cmd_t  entry,
	output logic           path_nonempty
);

	logic                                accept;
	logic                                curve;
	logic                                nonempty_q;
	logic signed [bcf_pkg::COORD_W-1:0]  pen_x_q;
	logic signed [bcf_pkg::COORD_W-1:0]  pen_y_q;

	assign cmd.ready     = !q_full;
	assign accept        = cmd.valid && cmd.ready;
	assign push          = accept && (cmd.action != bcf_pkg::ACT_BEGIN);
	assign curve         = (cmd.action == bcf_pkg::ACT_QUAD) || (cmd.action == bcf_pkg::ACT_CUBIC);
	assign path_nonempty = nonempty_q;

	// An empty path starts the curve at its first control point.
	always_comb begin
		entry.kind = cmd.action;
		entry.lead = curve && !nonempty_q;
		entry.p0_x = nonempty_q ? pen_x_q : cmd.ctrl1_x;
		entry.p0_y = nonempty_q ? pen_y_q : cmd.ctrl1_y;
		entry.c1_x = cmd.ctrl1_x;
		entry.c1_y = cmd.ctrl1_y;
		entry.c2_x = cmd.ctrl2_x;
		entry.c2_y = cmd.ctrl2_y;
		entry.e_x  = cmd.end_x;
		entry.e_y  = cmd.end_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q <= 1'b0;
		end else if (accept) begin
			unique case (cmd.action) inside
				bcf_pkg::ACT_BEGIN: begin
					nonempty_q <= 1'b0;
				end
				bcf_pkg::ACT_POINT, bcf_pkg::ACT_QUAD, bcf_pkg::ACT_CUBIC: begin
					nonempty_q <= 1'b1;
				end
			endcase
		end
	end

	// The last curve point lands exactly on the end point, so the pen follows it.
	always_ff @(posedge clk) begin
		if (push) begin
			pen_x_q <= cmd.end_x;
			pen_y_q <= cmd.end_y;
		end
	end

endmodule

// ===== rtl/bcf_queue.sv =====
module bcf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bcf_pkg::cmd_t  push_data,
	input  logic           pop,
	output bcf_pkg::cmd_t  head,
	output logic           full,
	output logic           empty
);

	localparam int PTR_W = (bcf_pkg::QUEUE_DEPTH > 1) ? $clog2(bcf_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(bcf_pkg::QUEUE_DEPTH + 1);

	bcf_pkg::cmd_t     slot_q [bcf_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = (count_q == CNT_W'(bcf_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(bcf_pkg::QUEUE_DEPTH - 1))
			return '0;
		return p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/bcf_back.sv =====
module bcf_back #(
	parameter int SEGMENTS  = bcf_pkg::SEGMENTS_DEFAULT,
	parameter int FRAC_BITS = bcf_pkg::FRAC_BITS_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bcf_pkg::cmd_t  head,
	input  logic           head_valid,
	output logic           pop,
	bcf_pt_if.source       pts
);

	localparam int CW = bcf_pkg::COORD_W;
	localparam int WW = FRAC_BITS + 1;          // unsigned Q1.FRAC_BITS weight
	localparam int PW = CW + WW + 1;            // signed product
	localparam int AW = PW + 2;                 // sum of four products
	localparam int RW = AW - FRAC_BITS;         // after dropping the fraction
	localparam int SW = $clog2(SEGMENTS + 1);
	localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;
	localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);
	localparam logic signed [RW-1:0] MAX_R = RW'(32'sh7fff_ffff);
	localparam logic signed [RW-1:0] MIN_R = RW'(32'sh8000_0000);

	// Bernstein weight tables, indexed by step
	logic [WW-1:0] quad_w  [SEGMENTS+1][4];
	logic [WW-1:0] cubic_w [SEGMENTS+1][4];

	for (genvar gi = 0; gi <= SEGMENTS; gi++) begin : g_w
		localparam longint unsigned SS = longint'(SEGMENTS);
		localparam longint unsigned SA = longint'(SEGMENTS - gi);
		localparam longint unsigned SI = longint'(gi);
		localparam longint unsigned DQ = SS * SS;
		localparam longint unsigned DC = SS * SS * SS;
		localparam longint unsigned WQ0 = (((SA * SA) << FRAC_BITS) + DQ / 2) / DQ;
		localparam longint unsigned WQ1 = (((2 * SA * SI) << FRAC_BITS) + DQ / 2) / DQ;
		localparam longint unsigned WQ2 = (((SI * SI) << FRAC_BITS) + DQ / 2) / DQ;
		localparam longint unsigned WC0 = (((SA * SA * SA) << FRAC_BITS) + DC / 2) / DC;
		localparam longint unsigned WC1 = (((3 * SA * SA * SI) << FRAC_BITS) + DC / 2) / DC;
		localparam longint unsigned WC2 = (((3 * SA * SI * SI) << FRAC_BITS) + DC / 2) / DC;
		localparam longint unsigned WC3 = (((SI * SI * SI) << FRAC_BITS) + DC / 2) / DC;
		assign quad_w[gi][0]  = WW'(WQ0);
		assign quad_w[gi][1]  = WW'(WQ1);
		assign quad_w[gi][2]  = '0;
		assign quad_w[gi][3]  = WW'(WQ2);
		assign cubic_w[gi][0] = WW'(WC0);
		assign cubic_w[gi][1] = WW'(WC1);
		assign cubic_w[gi][2] = WW'(WC2);
		assign cubic_w[gi][3] = WW'(WC3);
	end

	logic                  adv;
	logic                  issue;
	logic [SW-1:0]         step_q;
	logic                  lead_done_q;
	logic [WW-1:0]         sel_w [4];
	logic                  sel_last;
	logic                  sel_done;
	logic                  sel_lead;

	logic                  valid_s1, valid_s2, valid_s3;
	logic                  last_s1, last_s2, last_s3;
	logic [WW-1:0]         w_s1 [4];
	logic signed [CW-1:0]  x_s1 [4];
	logic signed [CW-1:0]  y_s1 [4];
	logic signed [PW-1:0]  px_s2 [4];
	logic signed [PW-1:0]  py_s2 [4];
	logic signed [AW-1:0]  sum_x_s3;
	logic signed [AW-1:0]  sum_y_s3;
	logic signed [AW-1:0]  rnd_x;
	logic signed [AW-1:0]  rnd_y;

	logic                  out_valid_q;
	logic signed [CW-1:0]  point_x_q;
	logic signed [CW-1:0]  point_y_q;
	logic                  last_q;

	function automatic logic signed [CW-1:0] sat(input logic signed [RW-1:0] v);
		if (v > MAX_R)
			return MAX_R[CW-1:0];
		if (v < MIN_R)
			return MIN_R[CW-1:0];
		return v[CW-1:0];
	endfunction

	// The whole pipe holds while the output beat waits.
	assign adv   = !out_valid_q || pts.ready;
	assign issue = adv && head_valid;
	assign pop   = issue && sel_done;

	// A plain point or a lead control point goes through the same datapath
	// with a single unit weight on that point.
	always_comb begin
		for (int k = 0; k < 4; k++)
			sel_w[k] = '0;
		sel_last = 1'b0;
		sel_done = 1'b0;
		sel_lead = 1'b0;
		if (head.kind == bcf_pkg::ACT_POINT) begin
			sel_w[3] = ONE;
			sel_last = 1'b1;
			sel_done = 1'b1;
		end else if (head.lead && !lead_done_q) begin
			sel_w[1] = ONE;
			sel_lead = 1'b1;
		end else begin
			for (int k = 0; k < 4; k++)
				sel_w[k] = (head.kind == bcf_pkg::ACT_CUBIC) ? cubic_w[step_q][k]
					: quad_w[step_q][k];
			sel_last = (step_q == SW'(SEGMENTS));
			sel_done = sel_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= SW'(1);
			lead_done_q <= 1'b0;
		end else if (issue) begin
			if (sel_done) begin
				step_q      <= SW'(1);
				lead_done_q <= 1'b0;
			end else if (sel_lead) begin
				lead_done_q <= 1'b1;
			end else begin
				step_q <= step_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= head_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_comb begin
		rnd_x = sum_x_s3 + HALF;
		rnd_y = sum_y_s3 + HALF;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1    <= sel_w;
			last_s1 <= sel_last;
			x_s1[0] <= head.p0_x;
			x_s1[1] <= head.c1_x;
			x_s1[2] <= head.c2_x;
			x_s1[3] <= head.e_x;
			y_s1[0] <= head.p0_y;
			y_s1[1] <= head.c1_y;
			y_s1[2] <= head.c2_y;
			y_s1[3] <= head.e_y;

			for (int k = 0; k < 4; k++) begin
				px_s2[k] <= x_s1[k] * $signed({1'b0, w_s1[k]});
				py_s2[k] <= y_s1[k] * $signed({1'b0, w_s1[k]});
			end
			last_s2 <= last_s1;

			sum_x_s3 <= AW'(px_s2[0]) + AW'(px_s2[1]) + AW'(px_s2[2]) + AW'(px_s2[3]);
			sum_y_s3 <= AW'(py_s2[0]) + AW'(py_s2[1]) + AW'(py_s2[2]) + AW'(py_s2[3]);
			last_s3  <= last_s2;

			point_x_q <= sat(rnd_x[AW-1:FRAC_BITS]);
			point_y_q <= sat(rnd_y[AW-1:FRAC_BITS]);
			last_q    <= last_s3;
		end
	end

	assign pts.valid      = out_valid_q;
	assign pts.point_x    = point_x_q;
	assign pts.point_y    = point_y_q;
	assign pts.last_point = last_q;

endmodule

// ===== rtl/bezier_curve_flattener_core.sv =====
// Bezier curve flattener: turns path commands into a stream of points.
// cmd channel (valid/ready): one beat per path command, action plus the
//   first and second control points and the end point, all signed Q16.16.
// pts channel (valid/ready): one beat per emitted point; last_point marks
//   the final point caused by a command.
// Begin emits nothing; point emits one beat; a quadratic or cubic emits
//   SEGMENTS beats, plus a leading beat holding the first control point
//   when the path was empty.
// A command's first beat passes the queue slot, the stage-one weight and
//   coordinate registers and the product, sum and output registers.
//   Throughput: one point per cycle while pts is not stalled, set by the
//   single weight-multiply datapath.
// The front end updates the pen and classifies each command at once and
//   parks it in a two-entry queue, so commands keep coming while points
//   drain. When pts is stalled the whole back pipeline holds, the queue
//   fills and cmd.ready drops.
// Reset clears the path flag, the queue and every pipeline valid; no
//   beat is emitted until a command arrives.
`include "assert_macros.svh"

module bezier_curve_flattener_core #(
	parameter int SEGMENTS  = bcf_pkg::SEGMENTS_DEFAULT,
	parameter int FRAC_BITS = bcf_pkg::FRAC_BITS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	bcf_cmd_if.sink   cmd,
	bcf_pt_if.source  pts
);

	logic           q_push;
	logic           q_pop;
	logic           q_full;
	logic           q_empty;
	logic           path_nonempty;
	bcf_pkg::cmd_t  q_in;
	bcf_pkg::cmd_t  q_head;

	// Front: pen tracking and command classification
	bcf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.q_full        (q_full),
		.push          (q_push),
		.entry         (q_in),
		.path_nonempty (path_nonempty)
	);

	// Decouple acceptance from point generation
	bcf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Back: step sequencer, weight multiply, round and saturate
	bcf_back #(
		.SEGMENTS  (SEGMENTS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.head_valid (!q_empty),
		.pop        (q_pop),
		.pts        (pts)
	);

	// Never push into a full queue nor pop an empty one.
	`BCF_ASSERT_IMPLY(a_no_overflow, clk, arst_n, q_push, !q_full, "queue overflow")
	`BCF_ASSERT_IMPLY(a_no_underflow, clk, arst_n, q_pop, !q_empty, "queue underflow")
	// Any drawing command leaves the path non-empty.
	`BCF_ASSERT_NEXT(a_path_marked, clk, arst_n, q_push, path_nonempty, "path not marked")

endmodule
